@@ rtl/core/tvn_pkg.sv @@
// Shared types, constants and register codes of the tiling value noise texel block.
package tvn_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int OCTAVES_DEF    = 5;

   // Lattice geometry
   localparam int BASE_LOG           = 3;   // base period 8
   localparam int SPECKLE_PERIOD     = 48;
   localparam int SPECKLE_WRAP_BITS  = 6;
   localparam int NOISE_LAT          = 6;   // register stages through one cell

   // Hash constants
   localparam logic [31:0] HASH_KX = 32'd374761393;
   localparam logic [31:0] HASH_KY = 32'd668265263;
   localparam logic [31:0] HASH_KS = 32'd2246822519;
   localparam logic [31:0] HASH_KM = 32'd1274126177;
   localparam int OCT_SEED_STEP    = 101;
   localparam int SPECKLE_SEED_OFS = 977;

   // Register reset values
   localparam logic [12:0] RESET_SIZE  = 13'd256;
   localparam logic [32:0] RESET_RECIP = 33'(64'd4294967296 / 64'd256);

   // Palette endpoints, scaled by 255 in Q16
   localparam logic [23:0] PAL_DARK_R  = 24'd2673869;
   localparam logic [23:0] PAL_DARK_G  = 24'd2172518;
   localparam logic [23:0] PAL_DARK_B  = 24'd1671168;
   localparam logic [23:0] PAL_LIGHT_R = 24'd7018906;
   localparam logic [23:0] PAL_LIGHT_G = 24'd5849088;
   localparam logic [23:0] PAL_LIGHT_B = 24'd4345037;

   typedef enum logic [1:0] {
      CSR_TEXTURE_SIZE = 2'd0,
      CSR_NOISE_SEED   = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [11:0] texel_col;
      logic [11:0] texel_row;
   } tvn_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } tvn_rsp_type;

endpackage

@@ rtl/core/tvn_recip.sv @@
// Restoring divider that forms floor(2^32 / texture_size) after a size write.
module tvn_recip import tvn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [12:0] size,
   output logic        busy,
   output logic [32:0] recip
);

   logic        active_ff, active_in;
   logic [12:0] size_ff, size_in;
   logic [12:0] rem_ff, rem_in;
   logic [32:0] quo_ff, quo_in;
   logic [5:0]  count_ff, count_in;
   logic [32:0] recip_ff, recip_in;
   logic [13:0] trial;
   logic [13:0] diff;

   always_comb begin
      active_in = active_ff;
      size_in   = size_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      count_in  = count_ff;
      recip_in  = recip_ff;
      // dividend 2^32: only its top bit is set
      trial = {rem_ff, (count_ff == 6'd0)};
      diff  = trial - {1'b0, size_ff};
      if (active_ff) begin
         if (trial >= {1'b0, size_ff}) begin
            rem_in = diff[12:0];
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = trial[12:0];
            quo_in = {quo_ff[31:0], 1'b0};
         end
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd32) begin
            active_in = 1'b0;
            recip_in  = quo_in;
         end
      end else if (load) begin
         if (size <= 13'd1) begin
            recip_in = 33'h1_0000_0000;   // zero size acts as one
         end else begin
            active_in = 1'b1;
            size_in   = size;
            rem_in    = '0;
            quo_in    = '0;
            count_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         recip_ff  <= RESET_RECIP;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         recip_ff  <= recip_in;
         count_ff  <= count_in;
      end
      size_ff <= size_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign busy  = active_ff;
   assign recip = recip_ff;

endmodule

@@ rtl/core/tvn_cell.sv @@
// Noise cell: hash four corners, interpolate, add an octave or set the speckle.
module tvn_cell import tvn_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int OCTAVES    = OCTAVES_DEF,
   parameter int OCT_INDEX  = 0,
   parameter bit SPECKLE    = 1'b0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [31:0]                 seed,
   input  logic                        in_valid,
   input  logic [COORD_BITS+18:0]      in_u,
   input  logic [COORD_BITS+18:0]      in_v,
   input  logic [OCTAVES+15:0]         in_acc,
   input  logic [15:0]                 in_sp,
   output logic                        out_valid,
   output logic [COORD_BITS+18:0]      out_u,
   output logic [COORD_BITS+18:0]      out_v,
   output logic [OCTAVES+15:0]         out_acc,
   output logic [15:0]                 out_sp
);

   localparam int UW    = COORD_BITS + 19;
   localparam int AW    = OCTAVES + 16;
   localparam int CW    = SPECKLE ? SPECKLE_WRAP_BITS : BASE_LOG + OCT_INDEX;
   localparam int DEPTH = NOISE_LAT - 1;
   localparam logic [31:0] SEED_OFS = SPECKLE ? 32'(SPECKLE_SEED_OFS)
                                              : 32'(OCT_INDEX * OCT_SEED_STEP);

   function automatic logic [15:0] mix_q16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [16:0] s);
      logic [33:0] sum;
      sum = 34'(a) * 34'(17'h10000 - s) + 34'(b) * 34'(s);
      return sum[31:16];
   endfunction

   logic [CW-1:0] wx_c, wy_c, wx1_c, wy1_c;
   logic [15:0]   fx_c, fy_c;

   if (SPECKLE) begin : g_speckle
      localparam int HW = UW - 17;
      localparam logic [31:0] MOD3_RECIP = 32'd1431655765;
      // u*6, integer part taken mod 48 as (ix/16 mod 3)*16 + ix mod 16
      function automatic logic [21:0] prep(input logic [UW-1:0] c);
         logic [UW+2:0]  x;
         logic [HW-1:0]  hi;
         logic [HW+31:0] prod;
         logic [HW-1:0]  q;
         logic [HW-1:0]  r;
         x    = ((UW+3)'(c) << 2) + ((UW+3)'(c) << 1);
         hi   = x[UW+2:20];
         prod = (HW+32)'(hi) * (HW+32)'(MOD3_RECIP);
         q    = prod[HW+31:32];
         r    = hi - (q << 1) - q;
         if (r >= HW'(3)) r = r - HW'(3);
         return {r[1:0], x[19:16], x[15:0]};
      endfunction
      assign {wx_c, fx_c} = prep(in_u);
      assign {wy_c, fy_c} = prep(in_v);
   end else begin : g_octave
      // u << o; period is a power of two so wrapping keeps the low bits
      function automatic logic [CW+15:0] prep(input logic [UW-1:0] c);
         logic [UW+OCT_INDEX-1:0] x;
         x = (UW+OCT_INDEX)'(c) << OCT_INDEX;
         return x[CW+15:0];
      endfunction
      assign {wx_c, fx_c} = prep(in_u);
      assign {wy_c, fy_c} = prep(in_v);
   end

   // stage 1: wrapped corners and fractions
   logic [CW-1:0] wx_ff, wy_ff;
   logic [15:0]   fx_ff, fy_ff;
   // stage 2: hash products, smoothstep partials
   logic [31:0]   hx0_ff, hx1_ff, hy0_ff, hy1_ff;
   logic [31:0]   f2x_ff, f2y_ff;
   logic [17:0]   tx_ff, ty_ff;
   // stage 3
   logic [31:0]   h_ff [4];
   logic [16:0]   sx3_ff, sy3_ff;
   // stage 4
   logic [31:0]   g_ff [4];
   logic [16:0]   sx4_ff, sy4_ff;
   // stage 5
   logic [15:0]   top_ff, bot_ff;
   logic [16:0]   sy5_ff;
   logic [31:0]   st_ff;

   logic [49:0]   sxp, syp;
   logic [31:0]   gm_in [4];
   logic [15:0]   val [4];
   logic [15:0]   n_c;

   assign wx1_c = (SPECKLE && wx_ff == CW'(SPECKLE_PERIOD - 1)) ? '0 : wx_ff + 1'b1;
   assign wy1_c = (SPECKLE && wy_ff == CW'(SPECKLE_PERIOD - 1)) ? '0 : wy_ff + 1'b1;
   assign sxp   = 50'(f2x_ff) * 50'(tx_ff);
   assign syp   = 50'(f2y_ff) * 50'(ty_ff);

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         gm_in[k] = (h_ff[k] ^ (h_ff[k] >> 13)) * HASH_KM;
         val[k]   = g_ff[k][15:0] ^ g_ff[k][31:16];
      end
   end

   assign n_c = mix_q16(top_ff, bot_ff, sy5_ff);

   always_ff @(posedge clock) begin
      st_ff <= (seed + SEED_OFS) * HASH_KS;

      wx_ff <= wx_c;
      wy_ff <= wy_c;
      fx_ff <= fx_c;
      fy_ff <= fy_c;

      hx0_ff <= 32'(wx_ff) * HASH_KX;
      hx1_ff <= 32'(wx1_c) * HASH_KX;
      hy0_ff <= 32'(wy_ff) * HASH_KY;
      hy1_ff <= 32'(wy1_c) * HASH_KY;
      f2x_ff <= 32'(fx_ff) * 32'(fx_ff);
      f2y_ff <= 32'(fy_ff) * 32'(fy_ff);
      tx_ff  <= 18'd196608 - {1'b0, fx_ff, 1'b0};
      ty_ff  <= 18'd196608 - {1'b0, fy_ff, 1'b0};

      h_ff[0] <= hx0_ff + hy0_ff + st_ff;
      h_ff[1] <= hx1_ff + hy0_ff + st_ff;
      h_ff[2] <= hx0_ff + hy1_ff + st_ff;
      h_ff[3] <= hx1_ff + hy1_ff + st_ff;
      sx3_ff  <= sxp[48:32];
      sy3_ff  <= syp[48:32];

      for (int k = 0; k < 4; k++) g_ff[k] <= gm_in[k];
      sx4_ff <= sx3_ff;
      sy4_ff <= sy3_ff;

      top_ff <= mix_q16(val[0], val[1], sx4_ff);
      bot_ff <= mix_q16(val[2], val[3], sx4_ff);
      sy5_ff <= sy4_ff;
   end

   // carried item data, aligned with the noise pipeline
   logic                 car_valid_ff [DEPTH];
   logic [UW-1:0]        car_u_ff     [DEPTH];
   logic [UW-1:0]        car_v_ff     [DEPTH];
   logic [AW-1:0]        car_acc_ff   [DEPTH];
   logic [15:0]          car_sp_ff    [DEPTH];
   logic                 out_valid_ff;
   logic [UW-1:0]        out_u_ff, out_v_ff;
   logic [AW-1:0]        out_acc_ff, out_acc_in;
   logic [15:0]          out_sp_ff, out_sp_in;

   if (SPECKLE) begin : g_sp_out
      assign out_acc_in = car_acc_ff[DEPTH-1];
      assign out_sp_in  = n_c;
   end else begin : g_oct_out
      assign out_acc_in = car_acc_ff[DEPTH-1] + (AW'(n_c) << (OCTAVES - 1 - OCT_INDEX));
      assign out_sp_in  = car_sp_ff[DEPTH-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DEPTH; k++) car_valid_ff[k] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         car_valid_ff[0] <= in_valid;
         for (int k = 1; k < DEPTH; k++) car_valid_ff[k] <= car_valid_ff[k-1];
         out_valid_ff <= car_valid_ff[DEPTH-1];
      end
      car_u_ff[0]   <= in_u;
      car_v_ff[0]   <= in_v;
      car_acc_ff[0] <= in_acc;
      car_sp_ff[0]  <= in_sp;
      for (int k = 1; k < DEPTH; k++) begin
         car_u_ff[k]   <= car_u_ff[k-1];
         car_v_ff[k]   <= car_v_ff[k-1];
         car_acc_ff[k] <= car_acc_ff[k-1];
         car_sp_ff[k]  <= car_sp_ff[k-1];
      end
      out_u_ff   <= car_u_ff[DEPTH-1];
      out_v_ff   <= car_v_ff[DEPTH-1];
      out_acc_ff <= out_acc_in;
      out_sp_ff  <= out_sp_in;
   end

   assign out_valid = out_valid_ff;
   assign out_u     = out_u_ff;
   assign out_v     = out_v_ff;
   assign out_acc   = out_acc_ff;
   assign out_sp    = out_sp_ff;

endmodule

@@ rtl/core/tvn_shade.sv @@
// Normalize octave sum, blend with speckle, clamp and map to palette bytes.
module tvn_shade import tvn_pkg::*; #(
   parameter int OCTAVES = OCTAVES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [OCTAVES+15:0] in_acc,
   input  logic [15:0]         in_sp,
   output logic                out_valid,
   output tvn_rsp_type         out_data
);

   localparam int AW = OCTAVES + 16;
   localparam longint DIV_OCT = (64'd1 << OCTAVES) - 64'd1;
   localparam logic [32:0] MAC_RECIP = 33'((64'd1 << 32) / DIV_OCT);
   localparam logic [31:0] FIVE_RECIP = 32'd858993459;

   // stage 1: quotient estimate of acc / (2^OCTAVES - 1)
   logic            v1_ff;
   logic [AW-1:0]   acc1_ff;
   logic [15:0]     sp1_ff, sp2_ff;
   logic [16:0]     q1_ff;
   logic [AW+32:0]  mprod;
   // stage 2
   logic            v2_ff;
   logic [15:0]     mac2_ff;
   logic [AW:0]     qd, mrem;
   logic [16:0]     mac_in;
   // stage 3: quotient estimate of (4*macro + speckle) / 5
   logic            v3_ff;
   logic [18:0]     num_c, num3_ff;
   logic [50:0]     fprod;
   logic [16:0]     q3_ff;
   // stage 4
   logic            v4_ff;
   logic [16:0]     t4_ff, t_in;
   logic [18:0]     frem;
   // stage 5
   logic            v5_ff;
   tvn_rsp_type     rsp_ff;
   logic [40:0]     pr, pg, pb;
   logic [23:0]     cr, cg, cb;

   assign mprod = (AW+33)'(in_acc) * (AW+33)'(MAC_RECIP);

   assign qd   = ((AW+1)'(q1_ff) << OCTAVES) - (AW+1)'(q1_ff);
   assign mrem = (AW+1)'(acc1_ff) - qd;
   assign mac_in = (mrem >= (AW+1)'(DIV_OCT)) ? q1_ff + 17'd1 : q1_ff;

   assign num_c = {1'b0, mac2_ff, 2'b00} + 19'(sp2_ff);
   assign fprod = 51'(num_c) * 51'(FIVE_RECIP);

   always_comb begin
      frem = num3_ff - ((19'(q3_ff) << 2) + 19'(q3_ff));
      t_in = (frem >= 19'd5) ? q3_ff + 17'd1 : q3_ff;
      if (t_in > 17'h10000) t_in = 17'h10000;
   end

   assign pr = 41'(PAL_LIGHT_R - PAL_DARK_R) * 41'(t4_ff);
   assign pg = 41'(PAL_LIGHT_G - PAL_DARK_G) * 41'(t4_ff);
   assign pb = 41'(PAL_LIGHT_B - PAL_DARK_B) * 41'(t4_ff);
   assign cr = PAL_DARK_R + pr[39:16];
   assign cg = PAL_DARK_G + pg[39:16];
   assign cb = PAL_DARK_B + pb[39:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      acc1_ff <= in_acc;
      sp1_ff  <= in_sp;
      q1_ff   <= mprod[48:32];
      mac2_ff <= mac_in[15:0];
      sp2_ff  <= sp1_ff;
      num3_ff <= num_c;
      q3_ff   <= fprod[48:32];
      t4_ff   <= t_in;
      rsp_ff.red   <= cr[23:16];
      rsp_ff.green <= cg[23:16];
      rsp_ff.blue  <= cb[23:16];
   end

   assign out_valid = v5_ff;
   assign out_data  = rsp_ff;

endmodule

@@ rtl/core/tiling_value_noise_texel.sv @@
// Top level of the tiling value noise texel generator.
// Give one texel coordinate per clock with start while busy is low; its RGB color
// comes out on rsp_data with a one-cycle rsp_valid strobe, in order. The result
// cannot be held off: sample it on the strobe. The rate is one texel per cycle
// while busy is low; the chain of noise cells is fully pipelined. A texture_size
// write whose size field (csr_data[12:0]) is above one starts a 33-step serial
// divide for the reciprocal of the size; busy is high and csr_ready low until it
// ends and no texel is taken. Sizes of zero or one and seed writes do not start it.
module tiling_value_noise_texel import tvn_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int OCTAVES    = OCTAVES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // texel requests
   input  logic        start,
   output logic        busy,
   input  tvn_req_type req_data,
   // colors
   output logic        rsp_valid,
   output tvn_rsp_type rsp_data,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int UW    = COORD_BITS + 19;   // lattice coordinate, Q16
   localparam int AW    = OCTAVES + 16;      // weighted octave sum
   localparam int CELLS = OCTAVES + 1;       // octaves, then the speckle layer

   logic        recip_busy;
   logic [32:0] recip;
   logic        size_wr;
   logic [31:0] seed_ff, seed_in;

   // a transfer on the register channel
   assign size_wr = csr_valid && csr_ready && (csr_index == CSR_TEXTURE_SIZE);
   assign seed_in = (csr_valid && csr_ready && (csr_index == CSR_NOISE_SEED))
                    ? csr_data : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else begin
         seed_ff <= seed_in;
      end
   end

   tvn_recip u_recip (
      .clock (clock),
      .reset (reset),
      .load  (size_wr),
      .size  (csr_data[12:0]),
      .busy  (recip_busy),
      .recip (recip)
   );

   assign busy      = recip_busy;
   assign csr_ready = ~recip_busy;

   // Coordinate scaling: u = col * floor(2^32/size) >> 13, Q16 lattice units.
   logic                  take;
   logic [COORD_BITS-1:0] col, row;
   logic [COORD_BITS+32:0] ucol, urow;
   logic                  sv_ff;
   logic [UW-1:0]         su_ff, sv2_ff;

   assign take = start && ~busy;
   assign col  = COORD_BITS'(req_data.texel_col);
   assign row  = COORD_BITS'(req_data.texel_row);
   assign ucol = (COORD_BITS+33)'(col) * (COORD_BITS+33)'(recip);
   assign urow = (COORD_BITS+33)'(row) * (COORD_BITS+33)'(recip);

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
      end else begin
         sv_ff <= take;
      end
      su_ff  <= ucol[COORD_BITS+31:13];
      sv2_ff <= urow[COORD_BITS+31:13];
   end

   // Cell chain: each octave cell adds its octave into the sum and hands the item on;
   // the last cell computes the speckle layer.
   logic          lk_valid [CELLS+1];
   logic [UW-1:0] lk_u     [CELLS+1];
   logic [UW-1:0] lk_v     [CELLS+1];
   logic [AW-1:0] lk_acc   [CELLS+1];
   logic [15:0]   lk_sp    [CELLS+1];

   assign lk_valid[0] = sv_ff;
   assign lk_u[0]     = su_ff;
   assign lk_v[0]     = sv2_ff;
   assign lk_acc[0]   = '0;
   assign lk_sp[0]    = '0;

   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      tvn_cell #(
         .COORD_BITS (COORD_BITS),
         .OCTAVES    (OCTAVES),
         .OCT_INDEX  (k),
         .SPECKLE    (k == OCTAVES)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .seed      (seed_ff),
         .in_valid  (lk_valid[k]),
         .in_u      (lk_u[k]),
         .in_v      (lk_v[k]),
         .in_acc    (lk_acc[k]),
         .in_sp     (lk_sp[k]),
         .out_valid (lk_valid[k+1]),
         .out_u     (lk_u[k+1]),
         .out_v     (lk_v[k+1]),
         .out_acc   (lk_acc[k+1]),
         .out_sp    (lk_sp[k+1])
      );
   end

   // Blend 0.8/0.2, clamp, palette. Coordinates leaving the last cell are spent.
   tvn_shade #(
      .OCTAVES (OCTAVES)
   ) u_shade (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lk_valid[CELLS]),
      .in_acc    (lk_acc[CELLS]),
      .in_sp     (lk_sp[CELLS]),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

@@ tb/tb_top.sv @@
// Testbench of the tiling value noise texel block: random texels against a bit-exact predictor.
`timescale 1ns / 1ps

module tb_top;
   import tvn_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 60;   // longer than the pipeline depth

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   tvn_req_type req_data = '0;
   logic        rsp_valid;
   tvn_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   tiling_value_noise_texel dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Predictor copy of the registers
   logic [12:0]       size_reg  = RESET_SIZE;
   longint unsigned   recip_reg = 64'd16777216;
   int unsigned       seed_reg  = 0;

   tvn_req_type texel_q[$];     // texels waiting to be sent
   tvn_rsp_type color_q[$];     // colors predicted, not yet seen
   int          errors = 0;
   int          cycles = 0;
   bit          no_gaps = 0;    // phase without sender idling
   int          gap = 0;

   function automatic longint unsigned lattice_value(longint unsigned cx, longint unsigned cy,
                                                     int unsigned period, int unsigned sd);
      int unsigned wx, wy, h;
      wx = int'(cx % period);
      wy = int'(cy % period);
      h = wx * HASH_KX + wy * HASH_KY + sd * HASH_KS;
      h = (h ^ (h >> 13)) * HASH_KM;
      h = h ^ (h >> 16);
      return longint'(h & 32'hFFFF);
   endfunction

   function automatic longint unsigned ease(longint unsigned f);
      return (f * f * (3 * 65536 - 2 * f)) >> 32;
   endfunction

   function automatic longint unsigned lerp(longint unsigned a, longint unsigned b,
                                            longint unsigned s);
      return (a * (65536 - s) + b * s) >> 16;
   endfunction

   function automatic longint unsigned cell_noise(longint unsigned x, longint unsigned y,
                                                  int unsigned period, int unsigned sd);
      longint unsigned ix, iy, sx, sy, top, bot;
      ix = x >> 16;
      iy = y >> 16;
      sx = ease(x & 16'hFFFF);
      sy = ease(y & 16'hFFFF);
      top = lerp(lattice_value(ix, iy, period, sd), lattice_value(ix + 1, iy, period, sd), sx);
      bot = lerp(lattice_value(ix, iy + 1, period, sd),
                 lattice_value(ix + 1, iy + 1, period, sd), sx);
      return lerp(top, bot, sy);
   endfunction

   function automatic tvn_rsp_type texel_color(tvn_req_type px);
      longint unsigned u, v, acc, macro_v, speck, t;
      longint unsigned dark[3], light[3];
      logic [7:0] ch[3];
      tvn_rsp_type c;
      dark[0] = PAL_DARK_R;  dark[1] = PAL_DARK_G;  dark[2] = PAL_DARK_B;
      light[0] = PAL_LIGHT_R; light[1] = PAL_LIGHT_G; light[2] = PAL_LIGHT_B;
      u = (longint'(px.texel_col) * recip_reg) >> 13;
      v = (longint'(px.texel_row) * recip_reg) >> 13;
      acc = 0;
      for (int o = 0; o < OCTAVES_DEF; o++)
         acc += cell_noise(u << o, v << o, 8 << o, seed_reg + o * OCT_SEED_STEP)
                << (OCTAVES_DEF - 1 - o);
      macro_v = acc / ((64'd1 << OCTAVES_DEF) - 1);
      speck = cell_noise(u * 6, v * 6, SPECKLE_PERIOD, seed_reg + SPECKLE_SEED_OFS);
      t = (4 * macro_v + speck) / 5;
      if (t > 65536) t = 65536;
      for (int k = 0; k < 3; k++)
         ch[k] = 8'((dark[k] + (((light[k] - dark[k]) * t) >> 16)) >> 16);
      c.red = ch[0];
      c.green = ch[1];
      c.blue = ch[2];
      return c;
   endfunction

   // Driver: one start assignment per edge; a transfer is start && !busy
   always @(posedge clock) begin
      logic nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         nxt = start;
         if (start && !busy) begin
            color_q.push_back(texel_color(req_data));
            nxt = 1'b0;
         end
         if (!nxt) begin
            if (gap > 0) begin
               gap--;
            end else if (texel_q.size() > 0) begin
               req_data <= texel_q.pop_front();
               nxt = 1'b1;
               gap = no_gaps ? 0 : $urandom_range(0, 4);
            end
         end
         start <= nxt;
      end
   end

   // Monitor: every strobe is one color transfer
   always @(posedge clock) begin
      tvn_rsp_type want;
      if (!reset && rsp_valid) begin
         if (color_q.size() == 0) begin
            $display("%0t: unexpected color %h", $time, rsp_data);
            errors++;
         end else begin
            want = color_q.pop_front();
            if (want.red !== rsp_data.red)
               $display("%0t: red expected %0d actual %0d", $time, want.red, rsp_data.red);
            if (want.green !== rsp_data.green)
               $display("%0t: green expected %0d actual %0d", $time, want.green,
                        rsp_data.green);
            if (want.blue !== rsp_data.blue)
               $display("%0t: blue expected %0d actual %0d", $time, want.blue, rsp_data.blue);
            if (want !== rsp_data) errors++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic size_recip_update(logic [12:0] s);
      size_reg = s;
      recip_reg = 64'd1 << 32;
      if (s > 1) recip_reg = (64'd1 << 32) / s;
   endtask

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      // transfer at this edge
      if (idx == CSR_TEXTURE_SIZE) begin
         size_recip_update(val[12:0]);
      end else if (idx == CSR_NOISE_SEED) begin
         seed_reg = val;
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (texel_q.size() > 0 || start || color_q.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic add_texel(int c, int r);
      tvn_req_type px;
      px.texel_col = c[11:0];
      px.texel_row = r[11:0];
      texel_q.push_back(px);
   endtask

   task automatic add_random(int n);
      int span;
      span = (size_reg == 0) ? 1 : (size_reg > 4096 ? 4096 : int'(size_reg));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0)
            add_texel($urandom_range(0, 4095), $urandom_range(0, 4095));
         else
            add_texel($urandom_range(0, span - 1), $urandom_range(0, span - 1));
      end
   endtask

   initial begin
      logic [31:0] sizes[8];
      logic [31:0] seeds[8];
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, coordinate extremes and beyond the size
      add_texel(0, 0);       add_texel(4095, 4095); add_texel(255, 255);
      add_texel(256, 256);   add_texel(4095, 0);    add_texel(0, 4095);
      add_texel(128, 37);    add_texel(2730, 1365); add_texel(1, 1);
      add_texel(31, 32);
      wait_idle();
      // Unused register indexes must be ignored
      csr_write(csr_index_type'(2), 32'hFFFF_FFFF);
      csr_write(csr_index_type'(3), 32'h1234_5678);
      add_texel(17, 200);    add_texel(4095, 4095);
      wait_idle();

      // size 1, 0 (taken as 1), max, above max, upper bits set, random; seeds extreme, random
      sizes = '{32'd1, 32'd0, 32'd4096, 32'd8191, 32'hFFFF_E0FF, 32'd3, 32'd256, 32'd0};
      seeds = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'h8000_0001, 32'd0, 32'd0, 32'd0, 32'd0};
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 7) sizes[ph] = $urandom_range(2, 4096);
         if (ph >= 4) seeds[ph] = $urandom;
         csr_write(CSR_TEXTURE_SIZE, sizes[ph]);
         csr_write(CSR_NOISE_SEED, seeds[ph]);
         no_gaps = ($urandom_range(0, 2) == 0);
         add_texel(0, 0);
         add_texel(4095, 4095);
         add_random(185);
         wait_idle();
      end

      if (color_q.size() != 0) errors++;
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/tvn_pkg.sv
rtl/core/tvn_recip.sv
rtl/core/tvn_cell.sv
rtl/core/tvn_shade.sv
rtl/core/tiling_value_noise_texel.sv
tb/tb_top.sv
